[src/brl_pkg.sv]
// Shared types and constants of the line rasterizer.
`default_nettype none
package brl_pkg;

  localparam int CoordW    = 12;   // endpoint coordinate width
  localparam int PosW      = 13;   // walking coordinate width
  localparam int DecW      = 15;   // decision variable width
  localparam int KeepW     = 14;   // increment when the minor axis holds
  localparam int ColorW    = 24;
  localparam int PixW      = 10;   // emitted pixel coordinate width
  localparam int AddrW     = 20;   // emitted address width
  localparam int QueueDepth = 2;

  localparam int FbWidthDefault  = 1024;
  localparam int FbHeightDefault = 1024;

  // Input beat kinds carried in tuser.
  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  // Command handed from the front end to the line walker.
  typedef struct packed {
    logic                     is_start;
    logic signed [PosW-1:0]   x;
    logic signed [PosW-1:0]   y;
    logic signed [PosW-1:0]   major_end;
    logic signed [DecW-1:0]   decision;
    logic        [KeepW-1:0]  inc_keep;
    logic signed [DecW-1:0]   inc_move;
    logic                     minor_down;
    logic                     x_is_major;
    logic        [ColorW-1:0] color;
  } cmd_t;

  // Valid and ready of one internal channel.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

[src/brl_front.sv]
// Front end: accepts input beats and works out the line setup for start beats.
`default_nettype none
module brl_front
  import brl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic                     action_i,
  input  wire logic signed [CoordW-1:0] x_start_i,
  input  wire logic signed [CoordW-1:0] y_start_i,
  input  wire logic signed [CoordW-1:0] x_end_i,
  input  wire logic signed [CoordW-1:0] y_end_i,
  input  wire logic        [ColorW-1:0] color_i,
  output hs_t                           cmd_hs_o,
  input  wire logic                     cmd_ready_i,
  output cmd_t                          cmd_o
);

  // First stage: differences, magnitudes and endpoint order.
  logic                     s1_valid_q;
  logic                     s1_start_q;
  logic signed [PosW-1:0]   s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  logic        [PosW-1:0]   s1_adx_q, s1_ady_q;
  logic                     s1_pos_q, s1_xswap_q, s1_yswap_q;
  logic        [ColorW-1:0] s1_color_q;

  logic signed [PosW-1:0] x0, y0, x1, y1, dx, dy;
  logic        [PosW-1:0] adx, ady;
  logic                   dx_nz, dy_nz;

  always_comb begin
    x0 = PosW'(x_start_i);
    y0 = PosW'(y_start_i);
    x1 = PosW'(x_end_i);
    y1 = PosW'(y_end_i);
    dx = x1 - x0;
    dy = y1 - y0;
    adx = dx[PosW-1] ? PosW'(-dx) : PosW'(dx);
    ady = dy[PosW-1] ? PosW'(-dy) : PosW'(dy);
    dx_nz = (dx != '0);
    dy_nz = (dy != '0);
  end

  assign ready_o = !s1_valid_q || cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      s1_start_q <= (action_i == ActStart);
      s1_x0_q    <= x0;
      s1_y0_q    <= y0;
      s1_x1_q    <= x1;
      s1_y1_q    <= y1;
      s1_adx_q   <= adx;
      s1_ady_q   <= ady;
      // Same nonzero sign on both axes walks the minor axis upward.
      s1_pos_q   <= dx_nz && dy_nz && (dx[PosW-1] == dy[PosW-1]);
      s1_xswap_q <= (x0 > x1);
      s1_yswap_q <= (y0 > y1);
      s1_color_q <= color_i;
    end
  end

  // Second stage: pick the major axis and build the command.
  logic                     x_major, swap;
  logic        [PosW-1:0]   amaj, amin;
  logic signed [PosW:0]     diff;

  always_comb begin
    x_major = (s1_adx_q > s1_ady_q);
    amaj    = x_major ? s1_adx_q : s1_ady_q;
    amin    = x_major ? s1_ady_q : s1_adx_q;
    swap    = x_major ? s1_xswap_q : s1_yswap_q;
    diff    = $signed({1'b0, amin}) - $signed({1'b0, amaj});

    cmd_o.is_start   = s1_start_q;
    cmd_o.x          = swap ? s1_x1_q : s1_x0_q;
    cmd_o.y          = swap ? s1_y1_q : s1_y0_q;
    if (x_major) begin
      cmd_o.major_end = swap ? s1_x0_q : s1_x1_q;
    end else begin
      cmd_o.major_end = swap ? s1_y0_q : s1_y1_q;
    end
    cmd_o.inc_keep   = {amin, 1'b0};
    cmd_o.inc_move   = {diff, 1'b0};
    cmd_o.decision   = $signed({1'b0, amin, 1'b0}) - $signed({2'b00, amaj});
    cmd_o.minor_down = !s1_pos_q;
    cmd_o.x_is_major = x_major;
    cmd_o.color      = s1_color_q;
  end

  assign cmd_hs_o.valid = s1_valid_q;
  assign cmd_hs_o.ready = cmd_ready_i;

endmodule
`default_nettype wire

[src/brl_queue.sv]
// Short command queue between the front end and the line walker.
`default_nettype none
module brl_queue
  import brl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire hs_t  wr_hs_i,
  output logic      wr_ready_o,
  input  wire cmd_t wr_cmd_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output cmd_t      rd_cmd_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  // The writer's ready is this queue's own ready handed back through the front end.
  assign do_wr      = wr_hs_i.valid && wr_hs_i.ready;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/brl_back.sv]
// Back end: walks the line one pixel per command and formats the pixel beat.
`default_nettype none
module brl_back
  import brl_pkg::*;
#(
  parameter int FB_WIDTH  = FbWidthDefault,
  parameter int FB_HEIGHT = FbHeightDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  output logic              cmd_ready_o,
  input  wire cmd_t         cmd_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [PixW-1:0]   pixel_x_o,
  output logic [PixW-1:0]   pixel_y_o,
  output logic [AddrW-1:0]  pixel_address_o,
  output logic [ColorW-1:0] pixel_color_o,
  output logic              written_o,
  output logic              last_o
);

  localparam logic [PosW-1:0]   FbWidthC  = PosW'(FB_WIDTH);
  localparam logic [PosW-1:0]   FbHeightC = PosW'(FB_HEIGHT);
  localparam int                ProdW     = 2 * PosW;

  // Line state.
  logic                     busy_q;
  logic signed [PosW-1:0]   cur_x_q, cur_y_q, major_end_q;
  logic signed [DecW-1:0]   decision_q, inc_move_q;
  logic        [KeepW-1:0]  inc_keep_q;
  logic                     minor_down_q, x_is_major_q;
  logic        [ColorW-1:0] line_color_q;

  // Pixel stage between the walker and the output register.
  logic                     p_valid_q;
  logic signed [PosW-1:0]   p_x_q, p_y_q;
  logic                     p_last_q;
  logic        [ColorW-1:0] p_color_q;

  logic out_ready, pix_ready, pop, emit;
  logic signed [PosW-1:0] nx_d, ny_d, minor_step, major_new, end_new;
  logic signed [DecW-1:0] dec_d;
  logic                   keep, is_last;

  assign out_ready   = !valid_o || ready_i;
  assign pix_ready   = !p_valid_q || out_ready;
  assign cmd_ready_o = pix_ready;
  assign pop         = cmd_valid_i && pix_ready;
  // A step that arrives with no line running is dropped.
  assign emit        = pop && (cmd_i.is_start || busy_q);

  always_comb begin
    keep       = decision_q[DecW-1];
    minor_step = minor_down_q ? -PosW'(1) : PosW'(1);
    nx_d       = cur_x_q;
    ny_d       = cur_y_q;
    if (x_is_major_q) begin
      nx_d = cur_x_q + PosW'(1);
      if (!keep) begin
        ny_d = cur_y_q + minor_step;
      end
    end else begin
      ny_d = cur_y_q + PosW'(1);
      if (!keep) begin
        nx_d = cur_x_q + minor_step;
      end
    end
    dec_d = keep ? decision_q + $signed({1'b0, inc_keep_q}) : decision_q + inc_move_q;
    if (cmd_i.is_start) begin
      major_new = cmd_i.x_is_major ? cmd_i.x : cmd_i.y;
      end_new   = cmd_i.major_end;
    end else begin
      major_new = x_is_major_q ? nx_d : ny_d;
      end_new   = major_end_q;
    end
    is_last = (major_new >= end_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      major_end_q  <= '0;
      decision_q   <= '0;
      inc_keep_q   <= '0;
      inc_move_q   <= '0;
      minor_down_q <= 1'b0;
      x_is_major_q <= 1'b0;
      line_color_q <= '0;
    end else if (emit) begin
      busy_q <= !is_last;
      if (cmd_i.is_start) begin
        cur_x_q      <= cmd_i.x;
        cur_y_q      <= cmd_i.y;
        major_end_q  <= cmd_i.major_end;
        decision_q   <= cmd_i.decision;
        inc_keep_q   <= cmd_i.inc_keep;
        inc_move_q   <= cmd_i.inc_move;
        minor_down_q <= cmd_i.minor_down;
        x_is_major_q <= cmd_i.x_is_major;
        line_color_q <= cmd_i.color;
      end else begin
        cur_x_q    <= nx_d;
        cur_y_q    <= ny_d;
        decision_q <= dec_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (pix_ready) begin
      p_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      p_x_q     <= cmd_i.is_start ? cmd_i.x : nx_d;
      p_y_q     <= cmd_i.is_start ? cmd_i.y : ny_d;
      p_last_q  <= is_last;
      p_color_q <= cmd_i.is_start ? cmd_i.color : line_color_q;
    end
  end

  // Mirror, range check and address.
  logic [PosW-1:0]  mx, my;
  logic [ProdW-1:0] addr_full;
  logic             in_range;

  always_comb begin
    mx        = p_x_q[PosW-1] ? PosW'(-p_x_q) : PosW'(p_x_q);
    my        = p_y_q[PosW-1] ? PosW'(-p_y_q) : PosW'(p_y_q);
    in_range  = (mx < FbWidthC) && (my < FbHeightC);
    addr_full = ProdW'(mx) + ProdW'(my) * ProdW'(FbWidthC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (out_ready) begin
      valid_o <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && p_valid_q) begin
      pixel_x_o       <= in_range ? mx[PixW-1:0] : '0;
      pixel_y_o       <= in_range ? my[PixW-1:0] : '0;
      pixel_address_o <= in_range ? addr_full[AddrW-1:0] : '0;
      pixel_color_o   <= p_color_q;
      written_o       <= in_range;
      last_o          <= p_last_q;
    end
  end

endmodule
`default_nettype wire

[src/bresenham_line_rasterizer.sv]
// Top level of the Bresenham line rasterizer.
//
// The slave stream takes command beats. tuser selects the kind: a start beat
// loads two signed endpoints and a color and emits the first pixel of the
// line; a step beat emits the next pixel. A step beat that arrives after the
// final pixel, or before any line, gives no pixel. A start beat while a line
// is running drops that line.
// The master stream gives one pixel beat per emitted pixel, in beat order.
// tlast marks the final pixel of the line and tuser is set when the pixel
// lies inside the framebuffer; outside it, x, y and address read zero.
// An accepted beat passes a setup register in the front end, the command
// queue, the pixel stage behind the line walker, and the mirror and address
// logic ahead of the output register.
// Throughput is one beat per cycle unless the receiver stalls; each step is
// one add on the decision register and one compare with the far major end.
// Reset empties the pipeline and the queue and leaves no line running.
// When the receiver stalls, the output register holds its beat, the stages
// behind it fill, and tready drops once the two-entry queue is full.
`default_nettype none
module bresenham_line_rasterizer
  import brl_pkg::*;
#(
  parameter int FB_WIDTH  = FbWidthDefault,
  parameter int FB_HEIGHT = FbHeightDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0: x_start[11:0], y_start[11:0], x_end[11:0],
  // y_end[11:0], color[23:0].
  input  wire logic [71:0] s_axis_tdata_i,
  // Fields from bit 0: action.
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // Fields from bit 0: pixel_x[9:0], pixel_y[9:0], pixel_address[19:0],
  // pixel_color[23:0].
  output logic [63:0]      m_axis_tdata_o,
  // Fields from bit 0: written.
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  hs_t  cmd_hs;
  cmd_t front_cmd, back_cmd;
  logic q_wr_ready, q_rd_valid, q_rd_ready;

  logic [PixW-1:0]   pixel_x, pixel_y;
  logic [AddrW-1:0]  pixel_address;
  logic [ColorW-1:0] pixel_color;

  brl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .action_i    (s_axis_tuser_i),
    .x_start_i   (s_axis_tdata_i[11:0]),
    .y_start_i   (s_axis_tdata_i[23:12]),
    .x_end_i     (s_axis_tdata_i[35:24]),
    .y_end_i     (s_axis_tdata_i[47:36]),
    .color_i     (s_axis_tdata_i[71:48]),
    .cmd_hs_o    (cmd_hs),
    .cmd_ready_i (q_wr_ready),
    .cmd_o       (front_cmd)
  );

  brl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_hs_i    (cmd_hs),
    .wr_ready_o (q_wr_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_cmd_o   (back_cmd)
  );

  brl_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_rd_valid),
    .cmd_ready_o     (q_rd_ready),
    .cmd_i           (back_cmd),
    .valid_o         (m_axis_tvalid_o),
    .ready_i         (m_axis_tready_i),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .pixel_address_o (pixel_address),
    .pixel_color_o   (pixel_color),
    .written_o       (m_axis_tuser_o),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {pixel_color, pixel_address, pixel_y, pixel_x};

endmodule
`default_nettype wire

[dv/brl_pixel_checker.sv]
// Checker that predicts the rasterizer's pixel beats and compares them.
`timescale 1ns / 1ps
module brl_pixel_checker
  import brl_pkg::*;
#(
  parameter int FB_WIDTH  = FbWidthDefault,
  parameter int FB_HEIGHT = FbHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          mismatches_o,
  output int          pixels_due_o
);

  // Fields of one pixel beat, most significant field first.
  typedef struct packed {
    logic [PixW-1:0]   x;
    logic [PixW-1:0]   y;
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic              written;
    logic              last;
  } pixel_t;

  pixel_t pixels_due[$];
  int     mismatches = 0;

  // Walker state of the line being drawn.
  logic                     line_busy;
  logic signed [PosW-1:0]   walk_x;
  logic signed [PosW-1:0]   walk_y;
  logic signed [PosW-1:0]   far_major;
  logic signed [DecW-1:0]   err_acc;
  logic        [KeepW-1:0]  err_keep;
  logic signed [DecW-1:0]   err_move;
  logic                     walk_down;
  logic                     x_major;
  logic        [ColorW-1:0] line_rgb;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Advances the walker by one command beat and works out the pixel it emits.
  task automatic rasterize(input logic act, input logic [71:0] cmd,
                           output logic emitted, output pixel_t px);
    int   x0, y0, x1, y1, dx, dy, adx, ady, mx, my, major;
    logic keep;
    logic in_fb;
    emitted = 1'b0;
    px      = '0;
    if (act == ActStart) begin
      x0  = int'($signed(cmd[11:0]));
      y0  = int'($signed(cmd[23:12]));
      x1  = int'($signed(cmd[35:24]));
      y1  = int'($signed(cmd[47:36]));
      dx  = x1 - x0;
      dy  = y1 - y0;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      walk_down = !((dx > 0 && dy > 0) || (dx < 0 && dy < 0));
      line_rgb  = cmd[71:48];
      x_major   = adx > ady;
      if (x_major) begin
        err_keep = KeepW'(2 * ady);
        err_move = DecW'(2 * (ady - adx));
        err_acc  = DecW'(2 * ady - adx);
        if (x0 > x1) begin
          walk_x = x1[PosW-1:0]; walk_y = y1[PosW-1:0]; far_major = x0[PosW-1:0];
        end else begin
          walk_x = x0[PosW-1:0]; walk_y = y0[PosW-1:0]; far_major = x1[PosW-1:0];
        end
      end else begin
        err_keep = KeepW'(2 * adx);
        err_move = DecW'(2 * (adx - ady));
        err_acc  = DecW'(2 * adx - ady);
        if (y0 > y1) begin
          walk_x = x1[PosW-1:0]; walk_y = y1[PosW-1:0]; far_major = y0[PosW-1:0];
        end else begin
          walk_x = x0[PosW-1:0]; walk_y = y0[PosW-1:0]; far_major = y1[PosW-1:0];
        end
      end
    end else if (line_busy) begin
      // A negative decision keeps the minor coordinate where it is.
      keep = err_acc < 0;
      if (x_major) begin
        walk_x = walk_x + PosW'(1);
        if (!keep) walk_y = walk_down ? walk_y - PosW'(1) : walk_y + PosW'(1);
      end else begin
        walk_y = walk_y + PosW'(1);
        if (!keep) walk_x = walk_down ? walk_x - PosW'(1) : walk_x + PosW'(1);
      end
      err_acc = keep ? err_acc + DecW'(err_keep) : err_acc + err_move;
    end else begin
      return;
    end

    mx    = walk_x < 0 ? -int'(walk_x) : int'(walk_x);
    my    = walk_y < 0 ? -int'(walk_y) : int'(walk_y);
    major = x_major ? int'(walk_x) : int'(walk_y);
    in_fb = (mx < FB_WIDTH) && (my < FB_HEIGHT);
    if (in_fb) begin
      px.x    = mx[PixW-1:0];
      px.y    = my[PixW-1:0];
      px.addr = AddrW'(mx + my * FB_WIDTH);
    end
    px.color   = line_rgb;
    px.written = in_fb;
    px.last    = major >= int'(far_major);
    line_busy  = !px.last;
    emitted    = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    pixel_t got;
    logic   emitted;
    if (!rst_ni) begin
      line_busy = 1'b0;
      walk_x    = '0;
      walk_y    = '0;
      far_major = '0;
      err_acc   = '0;
      err_keep  = '0;
      err_move  = '0;
      walk_down = 1'b0;
      x_major   = 1'b0;
      line_rgb  = '0;
      pixels_due.delete();
      pixels_due_o <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        rasterize(s_axis_tuser_i, s_axis_tdata_i, emitted, want);
        if (emitted) pixels_due.push_back(want);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[9:0], m_axis_tdata_i[19:10], m_axis_tdata_i[39:20],
               m_axis_tdata_i[63:40], m_axis_tuser_i, m_axis_tlast_i};
        if (pixels_due.size() == 0) begin
          $error("pixel beat x=%0d y=%0d arrived with no pixel due", got.x, got.y);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(got.x));
          check_field("pixel_y", 32'(want.y), 32'(got.y));
          check_field("pixel_address", 32'(want.addr), 32'(got.addr));
          check_field("pixel_color", 32'(want.color), 32'(got.color));
          check_field("written", 32'(want.written), 32'(got.written));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
      pixels_due_o <= pixels_due.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

[dv/bresenham_line_rasterizer_tb.sv]
// Testbench top: drives line commands into the rasterizer and gives the verdict.
`timescale 1ns / 1ps
module bresenham_line_rasterizer_tb;
  import brl_pkg::*;

  localparam int PixelBudget = 1700;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int mismatches;
  int pixels_due;
  int cycles = 0;
  bit no_idle = 1'b0;   // both sides run without gaps while set

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bresenham_line_rasterizer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  brl_pixel_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .pixels_due_o    (pixels_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: may hold tready low for a random stall before taking each pixel beat.
  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic logic [71:0] line_cmd(int xa, int ya, int xb, int yb,
                                           logic [23:0] rgb);
    return {rgb, yb[11:0], xb[11:0], ya[11:0], xa[11:0]};
  endfunction

  // Start coordinate inside +-span that keeps the far end in the 12-bit range.
  function automatic int pick_origin(int d, int span);
    int lo;
    int hi;
    lo = -span - (d < 0 ? d : 0);
    hi = span - 1 - (d > 0 ? d : 0);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Presents one command beat after a random gap and returns once it is taken.
  // tvalid only drops when a gap follows, so back-to-back beats stay high.
  task automatic send_beat(input logic act, input logic [71:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Step beats carry random payload, which the block must ignore.
  task automatic step_line(int count);
    repeat (count) send_beat(ActStep, 72'({$urandom(), $urandom(), $urandom()}));
  endtask

  initial begin
    int pixels_sent;
    int len;
    int minor;
    int dx;
    int dy;
    int x0;
    int y0;
    int span;
    int steps;
    bit paused;
    pixels_sent = 0;
    paused      = 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ActStart;
    rst_n    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines. A step before any line and a step after a finished
    // line give no pixel.
    step_line(1);
    send_beat(ActStart, line_cmd(0, 0, 0, 0, 24'hFFFFFF));      // single pixel
    step_line(1);
    // Horizontal run at the negative corner: mirrored far outside the frame.
    send_beat(ActStart, line_cmd(-2048, -2048, -2045, -2048, 24'h000000));
    step_line(3);
    // Equal spans go to y; walked from the smaller y with a falling minor.
    send_beat(ActStart, line_cmd(2047, 2040, 2040, 2047, 24'hA5A5A5));
    step_line(7);
    // Full-range diagonal, dropped after three pixels by the next start.
    send_beat(ActStart, line_cmd(2047, -2048, -2048, 2047, 24'h5A5A5A));
    step_line(2);
    // Crosses the right edge and the bottom edge of the frame at its corner.
    send_beat(ActStart, line_cmd(1022, 1023, 1025, 1024, 24'h123456));
    step_line(3);
    // Longest x span with a small falling y, dropped by the first random line.
    send_beat(ActStart, line_cmd(-2048, 5, 2047, 0, 24'hFEDCBA));
    step_line(1);

    // Random lines: mostly short and completed, some dropped midway, a few
    // long, with the odd stray step once a line has ended.
    while (pixels_sent < PixelBudget) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if (!paused && pixels_sent >= PixelBudget / 2) begin
        // Hold off until every pixel in flight has been taken.
        paused = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pixels_due != 0);
      end
      len   = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
      minor = $urandom_range(0, len);
      if ($urandom_range(0, 1)) begin
        dx = len;
        dy = minor;
      end else begin
        dx = minor;
        dy = len;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      span = $urandom_range(0, 1) ? 2048 : 1100;
      x0   = pick_origin(dx, span);
      y0   = pick_origin(dy, span);
      send_beat(ActStart, line_cmd(x0, y0, x0 + dx, y0 + dy, 24'($urandom())));
      steps = len;
      if (len > 0 && $urandom_range(0, 7) == 0) steps = $urandom_range(0, len - 1);
      step_line(steps);
      pixels_sent += steps + 1;
      if (steps == len && $urandom_range(0, 5) == 0) step_line($urandom_range(1, 2));
    end
    s_tvalid <= 1'b0;

    while (pixels_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pixels_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/brl_pkg.sv
src/brl_front.sv
src/brl_queue.sv
src/brl_back.sv
src/bresenham_line_rasterizer.sv
dv/brl_pixel_checker.sv
dv/bresenham_line_rasterizer_tb.sv
